// File: hdl/sfa_pkg.sv
// Shared types, constants and codes for the sprite fade and frame animator.
`default_nettype none

package sfa_pkg;

    localparam int TIME_W      = 24;
    localparam int FRAME_W     = 6;
    localparam int CNT_W       = 7;
    localparam int ALPHA_W     = 8;
    localparam int MODE_W      = 3;
    localparam int FSTATE_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int FADE_Q_BITS = 8;
    localparam int ITER_W      = $clog2(TIME_W + 1);

    localparam logic [CNT_W-1:0]   MAX_FRAMES      = 7'd64;
    localparam logic [CNT_W-1:0]   MIN_ANIM_FRAMES = 7'd2;
    localparam logic [ALPHA_W-1:0] FULL_ALPHA      = 8'd255;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK        = 3'd0,
        MODE_FADE_IN     = 3'd1,
        MODE_FADE_OUT    = 3'd2,
        MODE_SET_FRAME   = 3'd3,
        MODE_SET_PLAYING = 3'd4,
        MODE_SET_VISIBLE = 3'd5
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAMES_IN_USE = 2'd0,
        CFG_FRAME_PERIOD  = 2'd1,
        CFG_LOOP_ENABLE   = 2'd2,
        CFG_INITIAL_ALPHA = 2'd3
    } cfg_idx_t;

    typedef enum logic [FSTATE_W-1:0] {
        FADE_NONE = 2'd0,
        FADE_IN   = 2'd1,
        FADE_OUT  = 2'd2
    } fade_state_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [TIME_W-1:0]  amount;
        logic [FRAME_W-1:0] frame_req;
        logic               flag;
    } item_t;

    typedef struct packed {
        logic [ALPHA_W-1:0]  alpha;
        logic                shown;
        logic [FRAME_W-1:0]  frame;
        logic                running;
        logic [FSTATE_W-1:0] fade_state;
        logic                accepted;
    } result_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_EXEC,
        CMD_FADE_MUL,
        CMD_DIV_STEP,
        CMD_FADE_DONE,
        CMD_ANIM_LOAD,
        CMD_ANIM_FIN,
        CMD_ANIM_STOP,
        CMD_PUBLISH
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic fade_active;
        logic fade_ends;
        logic anim_on;
        logic stop_needed;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// File: hdl/sfa_if.sv
// Channel interfaces: input word, result word and configuration write.
`default_nettype none

interface sfa_in_if;
    import sfa_pkg::*;
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [TIME_W-1:0]  amount;
    logic [FRAME_W-1:0] frame_req;
    logic               flag;
    modport source (output valid, mode, amount, frame_req, flag, input ready);
    modport sink   (input valid, mode, amount, frame_req, flag, output ready);
endinterface

interface sfa_out_if;
    import sfa_pkg::*;
    logic                valid;
    logic                ready;
    logic [ALPHA_W-1:0]  alpha;
    logic                shown;
    logic [FRAME_W-1:0]  frame;
    logic                running;
    logic [FSTATE_W-1:0] fade_state;
    logic                accepted;
    modport source (output valid, alpha, shown, frame, running, fade_state, accepted,
                    input ready);
    modport sink   (input valid, alpha, shown, frame, running, fade_state, accepted,
                    output ready);
endinterface

interface sfa_cfg_if;
    import sfa_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/sfa_datapath.sv
// Sprite state, configuration registers, shared restoring divider and result register.
`default_nettype none

module sfa_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire sfa_pkg::cmd_t                cmd,
    output sfa_pkg::status_t                  st,
    input  wire sfa_pkg::item_t               item,
    input  wire logic                         cfg_we,
    input  wire logic [sfa_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [sfa_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output sfa_pkg::result_t                  result
);
    import sfa_pkg::*;

    // configuration
    logic [CNT_W-1:0]   frames_in_use_reg, frames_in_use_next;
    logic [TIME_W-1:0]  frame_period_reg, frame_period_next;
    logic               loop_enable_reg, loop_enable_next;

    // sprite state
    logic [ALPHA_W-1:0] cur_alpha_reg, cur_alpha_next;
    logic [ALPHA_W-1:0] base_reg, base_next;
    logic               vis_reg, vis_next;
    logic               fade_in_reg, fade_in_next;
    logic               fade_out_reg, fade_out_next;
    logic [TIME_W-1:0]  fade_el_reg, fade_el_next;
    logic [TIME_W-1:0]  fade_len_reg, fade_len_next;
    logic [FRAME_W-1:0] cur_frame_reg, cur_frame_next;
    logic [TIME_W-1:0]  frame_el_reg, frame_el_next;
    logic               play_reg, play_next;
    logic               out_valid_reg, out_valid_next;

    // working registers
    item_t              item_reg, item_next;
    logic               accepted_reg, accepted_next;
    logic [TIME_W-1:0]  rem_reg, rem_next;
    logic [TIME_W-1:0]  sh_reg, sh_next;
    logic [TIME_W-1:0]  q_reg, q_next;
    logic [TIME_W-1:0]  div_reg, div_next;
    logic [FRAME_W-1:0] m_reg, m_next;
    logic [TIME_W-1:0]  stop_prod_reg, stop_prod_next;
    result_t            res_reg, res_next;

    logic [CNT_W-1:0]   cnt_use;
    logic [TIME_W:0]    fade_sum;
    logic [TIME_W-1:0]  fade_sat;
    logic [TIME_W:0]    frame_sum;
    logic [TIME_W-1:0]  frame_sat;
    logic               fade_ends;
    logic [TIME_W-1:0]  fade_num;
    logic [31:0]        fade_prod;
    logic [TIME_W:0]    trial;
    logic               trial_ge;
    logic [TIME_W:0]    trial_diff;
    logic [CNT_W-1:0]   m_shift;
    logic [CNT_W-1:0]   m_wrap;
    logic [CNT_W-1:0]   cnt_m1;
    logic [CNT_W-1:0]   loop_sum;
    logic [CNT_W-1:0]   loop_wrap;
    logic [FRAME_W-1:0] m_minus1;
    logic [CNT_W-1:0]   cur_p1;
    logic [CNT_W-1:0]   steps;
    logic [CNT_W-1:0]   steps_p1;
    logic [30:0]        stop_full;
    logic               stop_needed;
    logic [ALPHA_W-1:0] fade_in_base;

    assign cnt_use   = (frames_in_use_reg > MAX_FRAMES) ? MAX_FRAMES : frames_in_use_reg;
    assign fade_sum  = {1'b0, fade_el_reg} + {1'b0, item_reg.amount};
    assign fade_sat  = fade_sum[TIME_W] ? '1 : fade_sum[TIME_W-1:0];
    assign frame_sum = {1'b0, frame_el_reg} + {1'b0, item_reg.amount};
    assign frame_sat = frame_sum[TIME_W] ? '1 : frame_sum[TIME_W-1:0];
    assign fade_ends = (fade_len_reg == '0) || (fade_sat >= fade_len_reg);

    assign fade_num  = fade_in_reg ? fade_el_reg : (fade_len_reg - fade_el_reg);
    assign fade_prod = 32'(base_reg) * 32'(fade_num);

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial      = {rem_reg, sh_reg[TIME_W-1]};
    assign trial_ge   = trial >= {1'b0, div_reg};
    assign trial_diff = trial - {1'b0, div_reg};
    // running remainder of the quotient modulo the frame count
    assign m_shift    = {m_reg, trial_ge};
    assign m_wrap     = m_shift - cnt_use;

    assign cnt_m1    = cnt_use - 7'd1;
    assign loop_sum  = {1'b0, cur_frame_reg} + {1'b0, m_reg};
    assign loop_wrap = loop_sum - cnt_use;
    assign m_minus1  = m_reg - 6'd1;
    assign cur_p1    = {1'b0, cur_frame_reg} + 7'd1;
    assign steps     = (cur_p1 < cnt_use) ? (cnt_use - cur_p1) : '0;
    assign steps_p1  = steps + 7'd1;
    assign stop_full = 31'(steps_p1) * 31'(frame_period_reg);
    assign stop_needed = !loop_enable_reg
                       && (q_reg > {{(TIME_W-CNT_W){1'b0}}, steps});

    assign fade_in_base = (base_reg == '0) ? FULL_ALPHA : base_reg;

    assign st.is_tick     = item_reg.mode == MODE_TICK;
    assign st.fade_active = fade_in_reg || fade_out_reg;
    assign st.fade_ends   = fade_ends;
    assign st.anim_on     = play_reg && (cnt_use >= MIN_ANIM_FRAMES)
                          && (frame_period_reg != '0);
    assign st.stop_needed = stop_needed;
    assign st.out_busy    = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    always_comb
    begin
        frames_in_use_next = frames_in_use_reg;
        frame_period_next  = frame_period_reg;
        loop_enable_next   = loop_enable_reg;
        cur_alpha_next     = cur_alpha_reg;
        base_next          = base_reg;
        vis_next           = vis_reg;
        fade_in_next       = fade_in_reg;
        fade_out_next      = fade_out_reg;
        fade_el_next       = fade_el_reg;
        fade_len_next      = fade_len_reg;
        cur_frame_next     = cur_frame_reg;
        frame_el_next      = frame_el_reg;
        play_next          = play_reg;
        item_next          = item_reg;
        accepted_next      = accepted_reg;
        rem_next           = rem_reg;
        sh_next            = sh_reg;
        q_next             = q_reg;
        div_next           = div_reg;
        m_next             = m_reg;
        stop_prod_next     = stop_prod_reg;
        res_next           = res_reg;
        out_valid_next     = (out_valid_reg && out_ready) ? 1'b0 : out_valid_reg;

        if (cfg_we)
        begin
            case (cfg_idx)
                CFG_FRAMES_IN_USE: frames_in_use_next = cfg_data[CNT_W-1:0];
                CFG_FRAME_PERIOD:  frame_period_next  = cfg_data[TIME_W-1:0];
                CFG_LOOP_ENABLE:   loop_enable_next   = cfg_data[0];
                // not stored: the reset alpha is always full scale
                CFG_INITIAL_ALPHA: ;
                default: ;
            endcase
        end

        case (cmd)
            CMD_LATCH:
            begin
                item_next     = item;
                accepted_next = 1'b1;
            end
            CMD_EXEC:
            begin
                case (item_reg.mode)
                    MODE_TICK:
                    begin
                        if (fade_in_reg || fade_out_reg)
                        begin
                            if (fade_ends)
                            begin
                                cur_alpha_next = fade_in_reg ? base_reg : '0;
                                vis_next       = fade_in_reg;
                                fade_in_next   = 1'b0;
                                fade_out_next  = 1'b0;
                                fade_el_next   = '0;
                                fade_len_next  = '0;
                            end
                            else
                            begin
                                fade_el_next = fade_sat;
                            end
                        end
                    end
                    MODE_FADE_IN:
                    begin
                        base_next = fade_in_base;
                        vis_next  = 1'b1;
                        fade_el_next = '0;
                        fade_out_next = 1'b0;
                        if (item_reg.amount == '0)
                        begin
                            cur_alpha_next = fade_in_base;
                            fade_in_next   = 1'b0;
                            fade_len_next  = '0;
                        end
                        else
                        begin
                            fade_in_next  = 1'b1;
                            fade_len_next = item_reg.amount;
                        end
                    end
                    MODE_FADE_OUT:
                    begin
                        if (cur_alpha_reg != '0)
                        begin
                            base_next = cur_alpha_reg;
                        end
                        fade_el_next = '0;
                        fade_in_next = 1'b0;
                        if (item_reg.amount == '0)
                        begin
                            cur_alpha_next = '0;
                            vis_next       = 1'b0;
                            fade_out_next  = 1'b0;
                            fade_len_next  = '0;
                        end
                        else
                        begin
                            vis_next      = 1'b1;
                            fade_out_next = 1'b1;
                            fade_len_next = item_reg.amount;
                        end
                    end
                    MODE_SET_FRAME:
                    begin
                        if (cnt_use == '0 || {1'b0, item_reg.frame_req} >= cnt_use)
                        begin
                            accepted_next = 1'b0;
                        end
                        else
                        begin
                            cur_frame_next = item_reg.frame_req;
                            frame_el_next  = '0;
                        end
                    end
                    MODE_SET_PLAYING:
                    begin
                        play_next = item_reg.flag;
                    end
                    MODE_SET_VISIBLE:
                    begin
                        vis_next = item_reg.flag;
                        if (!item_reg.flag)
                        begin
                            fade_in_next  = 1'b0;
                            fade_out_next = 1'b0;
                            fade_el_next  = '0;
                            fade_len_next = '0;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_FADE_MUL:
            begin
                rem_next = fade_prod[31:FADE_Q_BITS];
                sh_next  = {fade_prod[FADE_Q_BITS-1:0], {(TIME_W-FADE_Q_BITS){1'b0}}};
                div_next = fade_len_reg;
                q_next   = '0;
                m_next   = '0;
            end
            CMD_DIV_STEP:
            begin
                rem_next = trial_ge ? trial_diff[TIME_W-1:0] : trial[TIME_W-1:0];
                sh_next  = {sh_reg[TIME_W-2:0], 1'b0};
                q_next   = {q_reg[TIME_W-2:0], trial_ge};
                m_next   = (m_shift >= cnt_use) ? m_wrap[FRAME_W-1:0] : m_shift[FRAME_W-1:0];
            end
            CMD_FADE_DONE:
            begin
                cur_alpha_next = q_reg[ALPHA_W-1:0];
                vis_next       = 1'b1;
            end
            CMD_ANIM_LOAD:
            begin
                frame_el_next = frame_sat;
                rem_next      = '0;
                sh_next       = frame_sat;
                div_next      = frame_period_reg;
                q_next        = '0;
                m_next        = '0;
            end
            CMD_ANIM_FIN:
            begin
                stop_prod_next = stop_full[TIME_W-1:0];
                if (q_reg != '0)
                begin
                    if (loop_enable_reg)
                    begin
                        frame_el_next = rem_reg;
                        if ({1'b0, cur_frame_reg} >= cnt_use)
                        begin
                            cur_frame_next = (m_reg == '0) ? cnt_m1[FRAME_W-1:0] : m_minus1;
                        end
                        else
                        begin
                            cur_frame_next = (loop_sum >= cnt_use) ? loop_wrap[FRAME_W-1:0]
                                                                   : loop_sum[FRAME_W-1:0];
                        end
                    end
                    else if (stop_needed)
                    begin
                        cur_frame_next = cnt_m1[FRAME_W-1:0];
                        play_next      = 1'b0;
                    end
                    else
                    begin
                        cur_frame_next = cur_frame_reg + q_reg[FRAME_W-1:0];
                        frame_el_next  = rem_reg;
                    end
                end
            end
            CMD_ANIM_STOP:
            begin
                frame_el_next = frame_el_reg - stop_prod_reg;
            end
            CMD_PUBLISH:
            begin
                res_next.alpha      = cur_alpha_reg;
                res_next.shown      = vis_reg;
                res_next.frame      = cur_frame_reg;
                res_next.running    = play_reg;
                res_next.fade_state = fade_in_reg  ? FADE_IN :
                                      fade_out_reg ? FADE_OUT : FADE_NONE;
                res_next.accepted   = accepted_reg;
                out_valid_next      = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= '0;
            frame_period_reg  <= '0;
            loop_enable_reg   <= 1'b1;
            cur_alpha_reg     <= FULL_ALPHA;
            base_reg          <= FULL_ALPHA;
            vis_reg           <= 1'b1;
            fade_in_reg       <= 1'b0;
            fade_out_reg      <= 1'b0;
            fade_el_reg       <= '0;
            fade_len_reg      <= '0;
            cur_frame_reg     <= '0;
            frame_el_reg      <= '0;
            play_reg          <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            frames_in_use_reg <= frames_in_use_next;
            frame_period_reg  <= frame_period_next;
            loop_enable_reg   <= loop_enable_next;
            cur_alpha_reg     <= cur_alpha_next;
            base_reg          <= base_next;
            vis_reg           <= vis_next;
            fade_in_reg       <= fade_in_next;
            fade_out_reg      <= fade_out_next;
            fade_el_reg       <= fade_el_next;
            fade_len_reg      <= fade_len_next;
            cur_frame_reg     <= cur_frame_next;
            frame_el_reg      <= frame_el_next;
            play_reg          <= play_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        accepted_reg  <= accepted_next;
        rem_reg       <= rem_next;
        sh_reg        <= sh_next;
        q_reg         <= q_next;
        div_reg       <= div_next;
        m_reg         <= m_next;
        stop_prod_reg <= stop_prod_next;
        res_reg       <= res_next;
    end

    a_fade_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(fade_in_reg && fade_out_reg))
        else $error("fade in and fade out both active");

    a_fade_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        (fade_in_reg || fade_out_reg) |-> (fade_len_reg != '0))
        else $error("active fade with zero length");

    a_publish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_PUBLISH) |=> out_valid_reg)
        else $error("published word not presented");

endmodule

`default_nettype wire

// File: hdl/sfa_ctrl.sv
// Sequencer: steps one word through exec, fade divide, frame divide and publish.
`default_nettype none

module sfa_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire sfa_pkg::status_t st,
    output sfa_pkg::cmd_t        cmd
);
    import sfa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_FMUL,
        S_FDIV,
        S_FDONE,
        S_ALOAD,
        S_ADIV,
        S_AFIN,
        S_ASTOP,
        S_PUB
    } state_t;

    state_t              state_reg, state_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LATCH;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd = CMD_EXEC;
                if (!st.is_tick)
                    state_next = S_PUB;
                else if (st.fade_active)
                    state_next = st.fade_ends ? S_PUB : S_FMUL;
                else
                    state_next = st.anim_on ? S_ALOAD : S_PUB;
            end
            S_FMUL:
            begin
                cmd        = CMD_FADE_MUL;
                iter_next  = ITER_W'(FADE_Q_BITS);
                state_next = S_FDIV;
            end
            S_FDIV:
            begin
                cmd       = CMD_DIV_STEP;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1))
                    state_next = S_FDONE;
            end
            S_FDONE:
            begin
                cmd        = CMD_FADE_DONE;
                state_next = st.anim_on ? S_ALOAD : S_PUB;
            end
            S_ALOAD:
            begin
                cmd        = CMD_ANIM_LOAD;
                iter_next  = ITER_W'(TIME_W);
                state_next = S_ADIV;
            end
            S_ADIV:
            begin
                cmd       = CMD_DIV_STEP;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1))
                    state_next = S_AFIN;
            end
            S_AFIN:
            begin
                cmd        = CMD_ANIM_FIN;
                state_next = st.stop_needed ? S_ASTOP : S_PUB;
            end
            S_ASTOP:
            begin
                cmd        = CMD_ANIM_STOP;
                state_next = S_PUB;
            end
            S_PUB:
            begin
                if (!st.out_busy)
                begin
                    cmd        = CMD_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_PUBLISH) |-> !st.out_busy)
        else $error("result overwritten while waiting");

    a_accept_execs: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted word not executed");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FDIV || state_reg == S_ADIV) |-> (iter_reg != '0))
        else $error("divide step count ran out");

endmodule

`default_nettype wire

// File: hdl/sprite_fade_and_frame_animator.sv
// A command word goes through exec and publish; a tick may also take the fade path
// (multiply plus 8 divide steps) and the animation path (24 divide steps in the shared divider).
// Words are handled one at a time; the next word is taken the cycle after the result
// is registered, and publishing waits while the previous result is still held.
// Reset: alpha and base 255, visible, playing, frame 0, no fade, counters cleared,
// loop on, no frames in use, zero period; no result pending.
`default_nettype none

module sprite_fade_and_frame_animator (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sfa_cfg_if.sink    cfg,
    sfa_in_if.sink     in_ch,
    sfa_out_if.source  out_ch
);
    import sfa_pkg::*;

    cmd_t    cmd;
    status_t st;
    item_t   item;
    result_t result;
    logic    in_ready;
    logic    out_valid;

    assign cfg.ready = 1'b1;

    assign item.mode      = in_ch.mode;
    assign item.amount    = in_ch.amount;
    assign item.frame_req = in_ch.frame_req;
    assign item.flag      = in_ch.flag;
    assign in_ch.ready    = in_ready;

    assign out_ch.valid      = out_valid;
    assign out_ch.alpha      = result.alpha;
    assign out_ch.shown      = result.shown;
    assign out_ch.frame      = result.frame;
    assign out_ch.running    = result.running;
    assign out_ch.fade_state = result.fade_state;
    assign out_ch.accepted   = result.accepted;

    sfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    sfa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .item      (item),
        .cfg_we    (cfg.valid),
        .cfg_idx   (cfg.index),
        .cfg_data  (cfg.data),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .result    (result)
    );

endmodule

`default_nettype wire

// File: tb/sv/sfa_result_checker.sv
// Result checker for the sprite animator: tracks the sprite state and compares each result word.
`timescale 1ns / 100ps

module sfa_result_checker (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sfa_cfg_if          cfg,
    sfa_in_if           in_ch,
    sfa_out_if          out_ch,
    output int unsigned errors,
    output int unsigned pending
);
    import sfa_pkg::*;

    localparam longint unsigned TIME_MAX = (64'd1 << TIME_W) - 64'd1;

    logic [CNT_W-1:0]   frames_reg;
    logic [TIME_W-1:0]  period_reg;
    logic               loop_reg;
    logic [ALPHA_W-1:0] init_alpha_reg;

    logic [ALPHA_W-1:0] alpha_s;
    logic [ALPHA_W-1:0] base_s;
    logic               vis_s;
    logic               fade_in_s;
    logic               fade_out_s;
    logic [TIME_W-1:0]  fade_el_s;
    logic [TIME_W-1:0]  fade_len_s;
    logic [FRAME_W-1:0] frame_s;
    logic [TIME_W-1:0]  frame_el_s;
    logic               play_s;

    result_t     expected_words[$];
    int unsigned err_cnt;

    function automatic logic [TIME_W-1:0] sat_time(longint unsigned v);
        return (v > TIME_MAX) ? TIME_MAX[TIME_W-1:0] : v[TIME_W-1:0];
    endfunction

    function automatic longint unsigned frames_used();
        return (frames_reg > MAX_FRAMES) ? 64'(MAX_FRAMES) : 64'(frames_reg);
    endfunction

    function automatic void sprite_reset();
        frames_reg     = '0;
        period_reg     = '0;
        loop_reg       = 1'b1;
        init_alpha_reg = FULL_ALPHA;
        alpha_s        = init_alpha_reg;
        base_s         = init_alpha_reg;
        vis_s          = 1'b1;
        fade_in_s      = 1'b0;
        fade_out_s     = 1'b0;
        fade_el_s      = '0;
        fade_len_s     = '0;
        frame_s        = '0;
        frame_el_s     = '0;
        play_s         = 1'b1;
    endfunction

    function automatic void fade_finish();
        if (fade_in_s)
        begin
            alpha_s = base_s;
            vis_s   = 1'b1;
        end
        else
        begin
            alpha_s = '0;
            vis_s   = 1'b0;
        end
        fade_in_s  = 1'b0;
        fade_out_s = 1'b0;
        fade_el_s  = '0;
        fade_len_s = '0;
    endfunction

    function automatic void frame_advance(longint unsigned delta);
        longint unsigned cnt;
        longint unsigned per;
        longint unsigned el;
        longint unsigned n;
        longint unsigned rem;
        longint unsigned steps;
        cnt = frames_used();
        per = 64'(period_reg);
        if (!play_s || cnt < 64'(MIN_ANIM_FRAMES) || per == 0)
            return;
        el = 64'(sat_time(64'(frame_el_s) + delta));
        n = el / per;
        rem = el % per;
        frame_el_s = TIME_W'(el);
        if (n == 0)
            return;
        if (loop_reg)
        begin
            if (64'(frame_s) >= cnt)
                frame_s = FRAME_W'((n - 1) % cnt);
            else
                frame_s = FRAME_W'((64'(frame_s) + n) % cnt);
            frame_el_s = TIME_W'(rem);
        end
        else
        begin
            steps = (64'(frame_s) + 1 < cnt) ? cnt - 1 - 64'(frame_s) : 64'd0;
            if (n <= steps)
            begin
                frame_s = FRAME_W'(64'(frame_s) + n);
                frame_el_s = TIME_W'(rem);
            end
            else
            begin
                frame_s = FRAME_W'(cnt - 1);
                play_s = 1'b0;
                frame_el_s = TIME_W'(el - (steps + 1) * per);
            end
        end
    endfunction

    function automatic void time_tick(longint unsigned delta);
        if (fade_in_s || fade_out_s)
        begin
            fade_el_s = sat_time(64'(fade_el_s) + delta);
            if (fade_len_s == 0 || fade_el_s >= fade_len_s)
            begin
                fade_finish();
                return;
            end
            if (fade_in_s)
                alpha_s = ALPHA_W'((64'(base_s) * 64'(fade_el_s)) / 64'(fade_len_s));
            else
                alpha_s = ALPHA_W'((64'(base_s) * 64'(fade_len_s - fade_el_s))
                                   / 64'(fade_len_s));
            vis_s = 1'b1;
        end
        frame_advance(delta);
    endfunction

    function automatic result_t sprite_next(logic [MODE_W-1:0] mode, logic [TIME_W-1:0] amount,
                                            logic [FRAME_W-1:0] idx, logic flag);
        result_t r;
        logic    ok;
        ok = 1'b1;
        case (mode)
            MODE_TICK:
                time_tick(64'(amount));
            MODE_FADE_IN:
            begin
                if (base_s == 0)
                    base_s = FULL_ALPHA;
                fade_len_s = amount;
                fade_el_s  = '0;
                fade_in_s  = 1'b1;
                fade_out_s = 1'b0;
                vis_s      = 1'b1;
                if (amount == 0)
                    fade_finish();
            end
            MODE_FADE_OUT:
            begin
                if (alpha_s > 0)
                    base_s = alpha_s;
                fade_len_s = amount;
                fade_el_s  = '0;
                fade_in_s  = 1'b0;
                fade_out_s = 1'b1;
                vis_s      = 1'b1;
                if (amount == 0)
                    fade_finish();
            end
            MODE_SET_FRAME:
            begin
                if (frames_used() == 0 || 64'(idx) >= frames_used())
                    ok = 1'b0;
                else
                begin
                    frame_s    = idx;
                    frame_el_s = '0;
                end
            end
            MODE_SET_PLAYING:
                play_s = flag;
            MODE_SET_VISIBLE:
            begin
                vis_s = flag;
                if (!flag)
                begin
                    fade_in_s  = 1'b0;
                    fade_out_s = 1'b0;
                    fade_len_s = '0;
                    fade_el_s  = '0;
                end
            end
            default:
                ;
        endcase
        r.alpha      = alpha_s;
        r.shown      = vis_s;
        r.frame      = frame_s;
        r.running    = play_s;
        r.fade_state = fade_in_s ? FADE_IN : (fade_out_s ? FADE_OUT : FADE_NONE);
        r.accepted   = ok;
        return r;
    endfunction

    function automatic void report(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic void check_word(result_t e);
        report("alpha", 32'(e.alpha), 32'(out_ch.alpha));
        report("shown", 32'(e.shown), 32'(out_ch.shown));
        report("frame", 32'(e.frame), 32'(out_ch.frame));
        report("running", 32'(e.running), 32'(out_ch.running));
        report("fade_state", 32'(e.fade_state), 32'(out_ch.fade_state));
        report("accepted", 32'(e.accepted), 32'(out_ch.accepted));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_reset();
            expected_words.delete();
            err_cnt = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, got alpha %0d frame %0d",
                             $time, out_ch.alpha, out_ch.frame);
                    err_cnt++;
                end
                else
                    check_word(expected_words.pop_front());
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_FRAMES_IN_USE: frames_reg     = cfg.data[CNT_W-1:0];
                    CFG_FRAME_PERIOD:  period_reg     = cfg.data[TIME_W-1:0];
                    CFG_LOOP_ENABLE:   loop_reg       = cfg.data[0];
                    CFG_INITIAL_ALPHA: init_alpha_reg = cfg.data[ALPHA_W-1:0];
                    default:           ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                expected_words.push_back(sprite_next(in_ch.mode, in_ch.amount,
                                                     in_ch.frame_req, in_ch.flag));
            errors  <= err_cnt;
            pending <= expected_words.size();
        end
    end

endmodule

// File: tb/sv/sprite_fade_and_frame_animator_test.sv
// Testbench top for the sprite animator: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module sprite_fade_and_frame_animator_test;
    import sfa_pkg::*;

    localparam int LIMIT_CYCLES    = 400000;
    localparam int DRAIN_CYCLES    = 48;
    localparam int SETTLE_CYCLES   = 4;
    localparam int PHASES          = 10;
    localparam int WORDS_PER_PHASE = 60;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    logic             clk;
    logic             rst_n;
    int unsigned      errors;
    int unsigned      pending;
    int unsigned      cycles = 0;
    bit               no_idle;
    logic [CNT_W-1:0] frames_now;
    logic [TIME_W-1:0] period_now;

    sfa_cfg_if cfg_ch();
    sfa_in_if  in_ch();
    sfa_out_if out_ch();

    sprite_fade_and_frame_animator u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    sfa_result_checker u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("sprite_fade_and_frame_animator_test failed");
            $finish;
        end
    end

    function automatic int unsigned draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    task automatic send_word(logic [MODE_W-1:0] mode, logic [TIME_W-1:0] amount,
                             logic [FRAME_W-1:0] idx, logic flag);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.amount    <= amount;
        in_ch.frame_req <= idx;
        in_ch.flag      <= flag;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    task automatic wait_idle(int unsigned extra);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_regs(logic [CNT_W-1:0] frames, logic [TIME_W-1:0] period,
                            logic loop_on, logic [ALPHA_W-1:0] start_alpha);
        logic [CFG_DATA_W-1:0] words[4];
        words[CFG_FRAMES_IN_USE] = {17'($urandom), frames};
        words[CFG_FRAME_PERIOD]  = period;
        words[CFG_LOOP_ENABLE]   = {23'($urandom), loop_on};
        words[CFG_INITIAL_ALPHA] = {16'($urandom), start_alpha};
        for (int i = 0; i < 4; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= cfg_idx_t'(i);
            cfg_ch.data  <= words[i];
            @(posedge clk);
            while (!cfg_ch.ready) @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        frames_now = frames;
        period_now = period;
    endtask

    function automatic logic [TIME_W-1:0] tick_amount();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '1;
        if (sel == 1)
            return TIME_W'($urandom);
        if (sel < 10 && period_now != 0 && period_now <= 4096)
            return TIME_W'($urandom_range(0, 2 * int'(period_now)));
        if (sel < 10)
            return TIME_W'($urandom_range(0, 300));
        return TIME_W'($urandom_range(0, 64));
    endfunction

    function automatic logic [TIME_W-1:0] fade_amount();
        int unsigned sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return TIME_W'($urandom);
        return TIME_W'($urandom_range(1, 1000));
    endfunction

    task automatic random_word();
        int unsigned        pick;
        int unsigned        cnt;
        logic [MODE_W-1:0]  m;
        logic [TIME_W-1:0]  amt;
        logic [FRAME_W-1:0] ix;
        logic               fl;
        pick = $urandom_range(0, 99);
        cnt  = (frames_now > MAX_FRAMES) ? int'(MAX_FRAMES) : int'(frames_now);
        amt  = TIME_W'($urandom);
        ix   = FRAME_W'($urandom);
        fl   = 1'($urandom);
        if (pick < 45)
        begin
            m   = MODE_TICK;
            amt = tick_amount();
        end
        else if (pick < 55)
        begin
            m   = MODE_FADE_IN;
            amt = fade_amount();
        end
        else if (pick < 65)
        begin
            m   = MODE_FADE_OUT;
            amt = fade_amount();
        end
        else if (pick < 78)
        begin
            m = MODE_SET_FRAME;
            if (cnt != 0 && $urandom_range(0, 4) != 0)
                ix = FRAME_W'($urandom_range(0, cnt - 1));
        end
        else if (pick < 88)
        begin
            m  = MODE_SET_PLAYING;
            fl = ($urandom_range(0, 3) != 0);
        end
        else if (pick < 97)
        begin
            m  = MODE_SET_VISIBLE;
            fl = ($urandom_range(0, 3) != 0);
        end
        else
            m = ($urandom_range(0, 1) != 0) ? MODE_SPARE_LO : MODE_SPARE_HI;
        send_word(m, amt, ix, fl);
    endtask

    initial
    begin
        int unsigned gap;
        out_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        no_idle         = 1'b0;
        frames_now      = '0;
        period_now      = '0;
        in_ch.valid     = 1'b0;
        in_ch.mode      = MODE_TICK;
        in_ch.amount    = '0;
        in_ch.frame_req = '0;
        in_ch.flag      = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_FRAMES_IN_USE;
        cfg_ch.data     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: no frames, zero period, looping
        send_word(MODE_TICK, '0, '0, 1'b0);
        send_word(MODE_SPARE_LO, '1, '1, 1'b1);
        send_word(MODE_SPARE_HI, '1, '1, 1'b1);
        send_word(MODE_SET_FRAME, '0, '0, 1'b0);
        send_word(MODE_FADE_OUT, '0, '0, 1'b0);
        send_word(MODE_FADE_IN, 24'd100, '0, 1'b0);
        send_word(MODE_TICK, 24'd30, '0, 1'b0);
        send_word(MODE_TICK, 24'd30, '0, 1'b0);
        send_word(MODE_TICK, 24'd40, '0, 1'b0);
        send_word(MODE_FADE_OUT, '1, '0, 1'b0);
        send_word(MODE_TICK, 24'd1000, '0, 1'b0);
        send_word(MODE_TICK, '1, '0, 1'b0);
        send_word(MODE_FADE_IN, 24'd500, '0, 1'b0);
        send_word(MODE_SET_VISIBLE, '0, '0, 1'b0);
        send_word(MODE_SET_VISIBLE, '0, '0, 1'b1);
        send_word(MODE_SET_PLAYING, '0, '0, 1'b0);
        send_word(MODE_SET_PLAYING, '0, '0, 1'b1);

        // five frames, no looping: range checks and stop on last frame
        wait_idle(SETTLE_CYCLES);
        set_regs(7'd5, 24'd100, 1'b0, 8'h80);
        send_word(MODE_SET_FRAME, '0, 6'd4, 1'b0);
        send_word(MODE_SET_FRAME, '0, 6'd5, 1'b0);
        send_word(MODE_SET_FRAME, '0, 6'd63, 1'b0);
        send_word(MODE_TICK, 24'd100, '0, 1'b0);
        send_word(MODE_SET_PLAYING, '0, '0, 1'b1);
        send_word(MODE_SET_FRAME, '0, 6'd0, 1'b0);
        send_word(MODE_TICK, 24'd350, '0, 1'b0);
        send_word(MODE_TICK, '1, '0, 1'b0);

        // count shrinks below the current frame, looping
        wait_idle(SETTLE_CYCLES);
        set_regs(7'd3, 24'd7, 1'b1, 8'hFF);
        send_word(MODE_SET_PLAYING, '0, '0, 1'b1);
        send_word(MODE_TICK, 24'd20, '0, 1'b0);
        send_word(MODE_FADE_IN, '0, '0, 1'b0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle(SETTLE_CYCLES);
            no_idle = (phase % 4 == 3);
            case (phase)
                0: set_regs(7'd64, 24'd1, 1'b1, 8'd0);
                1: set_regs(7'd127, 24'hFFFFFF, 1'b0, 8'd255);
                2: set_regs(7'd2, 24'd16, 1'b0, 8'h5A);
                3: set_regs(7'd1, 24'd50, 1'b1, 8'hA5);
                4: set_regs(7'd0, 24'd0, 1'b0, 8'h01);
                5: set_regs(7'd64, 24'd0, 1'b1, 8'h7F);
                default:
                    set_regs(CNT_W'($urandom_range(0, 70)),
                             ($urandom_range(0, 7) == 0) ? 24'd0
                                                         : TIME_W'($urandom_range(1, 200)),
                             1'($urandom), ALPHA_W'($urandom));
            endcase
            send_word(MODE_SET_PLAYING, '0, '0, 1'b1);
            for (int k = 0; k < WORDS_PER_PHASE; k++)
                random_word();
        end

        wait_idle(DRAIN_CYCLES);
        if (errors == 0 && pending == 0)
            $display("sprite_fade_and_frame_animator_test passed");
        else
            $display("sprite_fade_and_frame_animator_test failed");
        $finish;
    end

endmodule
